[rtl/core/sap_pkg.sv]
`timescale 1ns / 1ps

package sap_pkg;

  // Field widths of the request and result words.
  localparam int RectW    = 11;
  localparam int SizeW    = 12;  // padded rectangle side, up to 2048
  localparam int PagesW   = 8;
  localparam int PosW     = 12;
  localparam int PenW     = 13;
  localparam int ShelfHW  = 12;
  localparam int SideW    = 13;  // saturated page side, up to MAX_PAGE_SIDE and at most 4095
  localparam int CmpW     = 14;  // room for a 13-bit position plus a 12-bit size
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 12;
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  localparam logic [CfgDataW-1:0] PageSizeReset = 12'd256;
  localparam logic [PagesW-1:0]   MaxPagesReset = 8'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_SIZE = 4'd0,
    CFG_MAX_PAGES = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [RectW-1:0] rect_height;
    logic [RectW-1:0] rect_width;
  } req_t;

  typedef struct packed {
    logic              placed;
    logic [PosW-1:0]   pos_y;
    logic [PosW-1:0]   pos_x;
    logic [PagesW-1:0] page_index;
  } res_t;

  typedef struct packed {
    logic [SideW-1:0]  side;
    logic [PagesW-1:0] max_pages;
  } cfg_t;

endpackage

[rtl/core/shelf_atlas_packer_core.sv]
`timescale 1ns / 1ps

// Shelf packer for square atlas pages. Each input word asks for a rectangle;
// the block pads it by one pixel right and bottom, puts it on the current
// shelf, opens a new shelf below when the row is full and a new page when the
// shelf runs off the bottom, and returns one output word per request with the
// page index and top-left position, or placed = 0 for a zero size or when the
// page limit is reached. A word is taken every clock cycle while the output is
// not stalled. The accepting edge loads the input register, the placement runs
// on the held request, and the result register takes the result once the
// output is free; out_tvalid comes from the result register. The placement is
// one pass through a few adds and compares on the running pen, shelf and page
// registers. Backpressure on the output stalls the input register, which keeps
// taking words until it holds one that cannot move. The user must write
// page_size and max_pages through the cfg port only while no request is in
// flight; the block does not enforce this. page_size above MAX_PAGE_SIDE saturates to it.

module shelf_atlas_packer_core #(
  parameter int MAX_PAGE_SIDE = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: rect_width [10:0], rect_height [21:11], zero [23:22]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sap_pkg::InDataW-1:0]       in_tdata,
  // out_tdata: page_index [7:0], pos_x [19:8], pos_y [31:20]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sap_pkg::OutDataW-1:0]      out_tdata,
  // out_tuser: placed [0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sap_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [sap_pkg::CfgDataW-1:0]      cfg_data
);

  sap_pkg::cfg_t cfg;
  sap_pkg::req_t req_r, req_nxt;
  sap_pkg::res_t res, res_r, res_nxt;
  logic          req_valid_r, req_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          adv;
  logic          in_acc;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  sap_cfg #(
    .MAX_PAGE_SIDE (MAX_PAGE_SIDE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held request moves on whenever the result register is empty or is
  // being drained in this cycle.
  assign adv       = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  sap_place u_place (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_acc) begin
      req_valid_nxt = 1'b1;
    end else if (adv) begin
      req_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    req_nxt = in_acc ? sap_pkg::req_t'(in_tdata[2*sap_pkg::RectW-1:0]) : req_r;
    res_nxt = adv ? res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.pos_y, res_r.pos_x, res_r.page_index};
  assign out_tuser  = res_r.placed;

endmodule

[rtl/core/sap_cfg.sv]
`timescale 1ns / 1ps

module sap_cfg #(
  parameter int MAX_PAGE_SIDE = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [sap_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sap_pkg::CfgDataW-1:0]     cfg_data,
  output sap_pkg::cfg_t                    cfg
);

  localparam logic [sap_pkg::SideW-1:0] MaxSide = sap_pkg::SideW'(MAX_PAGE_SIDE);
  localparam logic [sap_pkg::SideW-1:0] ResetSide =
    ({1'b0, sap_pkg::PageSizeReset} > MaxSide) ? MaxSide : {1'b0, sap_pkg::PageSizeReset};

  logic [sap_pkg::SideW-1:0]  side_r, side_nxt;
  logic [sap_pkg::PagesW-1:0] max_pages_r, max_pages_nxt;
  logic [sap_pkg::SideW-1:0]  wr_side;

  // The page side is saturated once, when it is written.
  assign wr_side = ({1'b0, cfg_data} > MaxSide) ? MaxSide : {1'b0, cfg_data};

  always_comb begin
    side_nxt      = side_r;
    max_pages_nxt = max_pages_r;
    if (cfg_valid) begin
      unique case (sap_pkg::cfg_reg_t'(cfg_index))
        sap_pkg::CFG_PAGE_SIZE: side_nxt      = wr_side;
        sap_pkg::CFG_MAX_PAGES: max_pages_nxt = cfg_data[sap_pkg::PagesW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= ResetSide;
      max_pages_r <= sap_pkg::MaxPagesReset;
    end else begin
      side_r      <= side_nxt;
      max_pages_r <= max_pages_nxt;
    end
  end

  assign cfg.side      = side_r;
  assign cfg.max_pages = max_pages_r;

endmodule

[rtl/core/sap_place.sv]
`timescale 1ns / 1ps

module sap_place (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  sap_pkg::req_t req,
  input  sap_pkg::cfg_t cfg,
  output sap_pkg::res_t res
);

  localparam int CmpW = sap_pkg::CmpW;

  logic [sap_pkg::PenW-1:0]    pen_r, pen_nxt;
  logic [sap_pkg::PenW-1:0]    top_r, top_nxt;
  logic [sap_pkg::ShelfHW-1:0] sh_r, sh_nxt;
  logic [sap_pkg::PagesW-1:0]  po_r, po_nxt;

  logic [sap_pkg::SizeW-1:0]   pw, ph;
  logic [CmpW-1:0]             side_c;
  logic                        zero, po_zero, cond1, close, need1, fail1, open1;
  logic                        need2, fail2, open2, ok;
  logic [sap_pkg::PenW-1:0]    pen1, top1, pen2, top2, pen3, top3;
  logic [sap_pkg::ShelfHW-1:0] sh1, sh2, sh3;
  logic [sap_pkg::PagesW-1:0]  po2, po3;

  always_comb begin
    zero    = (req.rect_width == '0) || (req.rect_height == '0);
    pw      = {1'b0, req.rect_width} + sap_pkg::SizeW'(1);
    ph      = {1'b0, req.rect_height} + sap_pkg::SizeW'(1);
    side_c  = CmpW'(cfg.side);
    po_zero = (po_r == '0);

    // First step: close the shelf when the rectangle runs past the right edge.
    cond1 = po_zero || ((CmpW'(pen_r) + CmpW'(pw)) > side_c);
    close = cond1 && !po_zero;
    top1  = close ? top_r + sap_pkg::PenW'(sh_r) : top_r;
    pen1  = close ? '0 : pen_r;
    sh1   = close ? '0 : sh_r;

    need1 = cond1 && (po_zero || ((CmpW'(top1) + CmpW'(ph)) > side_c));
    fail1 = need1 && (po_r >= cfg.max_pages);
    open1 = need1 && !fail1;
    po2   = open1 ? po_r + sap_pkg::PagesW'(1) : po_r;
    pen2  = open1 ? '0 : pen1;
    top2  = open1 ? '0 : top1;
    sh2   = open1 ? '0 : sh1;

    // Second step: the shelf must also fit vertically, even on a fresh page.
    need2 = !fail1 && ((CmpW'(top2) + CmpW'(ph)) > side_c);
    fail2 = need2 && (po2 >= cfg.max_pages);
    open2 = need2 && !fail2;
    po3   = open2 ? po2 + sap_pkg::PagesW'(1) : po2;
    pen3  = open2 ? '0 : pen2;
    top3  = open2 ? '0 : top2;
    sh3   = open2 ? '0 : sh2;

    ok = !zero && !fail1 && !fail2;

    res.placed     = ok;
    res.page_index = ok ? po3 - sap_pkg::PagesW'(1) : '0;
    res.pos_x      = ok ? pen3[sap_pkg::PosW-1:0] : '0;
    res.pos_y      = ok ? top3[sap_pkg::PosW-1:0] : '0;

    // A failed page open keeps whatever was already done before it.
    pen_nxt = pen_r;
    top_nxt = top_r;
    sh_nxt  = sh_r;
    po_nxt  = po_r;
    if (step && !zero) begin
      if (fail1) begin
        pen_nxt = pen1;
        top_nxt = top1;
        sh_nxt  = sh1;
      end else if (fail2) begin
        pen_nxt = pen2;
        top_nxt = top2;
        sh_nxt  = sh2;
        po_nxt  = po2;
      end else begin
        pen_nxt = pen3 + sap_pkg::PenW'(pw);
        top_nxt = top3;
        sh_nxt  = (ph > sh3) ? ph : sh3;
        po_nxt  = po3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
      top_r <= '0;
      sh_r  <= '0;
      po_r  <= '0;
    end else begin
      pen_r <= pen_nxt;
      top_r <= top_nxt;
      sh_r  <= sh_nxt;
      po_r  <= po_nxt;
    end
  end

endmodule

[rtl/core/sap_checker.sv]
`timescale 1ns / 1ps

module sap_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sap_pkg::OutDataW-1:0]      out_tdata,
  input logic                              out_tuser
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A request that could not be placed reports all-zero position fields.
  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("unplaced result carries nonzero fields");

  // A placed rectangle never lands on page 255.
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] != 8'hFF)
    else $error("page index out of range");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With an empty pipe and a free output, the input side is ready.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid && !out_tvalid && $past(!in_tvalid) && $past(rst_n) |-> in_tready)
    else $error("input not ready while idle");

endmodule

bind shelf_atlas_packer_core sap_checker u_sap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
